>>> sv/pwk_pkg.sv
// ----------------------------------------------------------------------------
// pwk_pkg
// Shared types and constants for the two-level page walk core: command and
// status codes, address field widths, queue transaction and back-end states.
// ----------------------------------------------------------------------------
package pwk_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int VA_W     = 15;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int PAGE_W   = 7;
    localparam int OFF_W    = 5;
    localparam int STORE_AW = PAGE_W + OFF_W;

    // Entry layout
    localparam int VALID_BIT = 7;

    // Directory page after reset
    localparam logic [PAGE_W-1:0] DIR_RESET = 7'h6c;

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_WR_MEM  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_DISK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WALK    = 2'd2;

    // Status codes on the output channel
    localparam logic [STATUS_W-1:0] ST_MEM   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DISK  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAULT = 2'd2;

    // Decoded operation carried through the queue
    typedef enum logic [1:0] {
        OP_WR_MEM,
        OP_WR_DISK,
        OP_WALK
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [VA_W-1:0]   addr;
        logic [BYTE_W-1:0] wdata;
    } q_entry_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Back-end walk sequencer states
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIR,
        BS_TAB,
        BS_DAT
    } b_state_t;

endpackage

>>> sv/two_level_page_walk_core.sv
// ----------------------------------------------------------------------------
// two_level_page_walk_core
// Two-level page table walk over a 4 KiB byte memory and a 4 KiB disk image.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): command, address, write_data.
//   Command 0 writes a memory byte, 1 writes a disk byte, 2 translates a
//   15-bit virtual address; code 3 is accepted and dropped. Writes produce
//   no output transaction; each translation produces exactly one.
//   Output channel (out_valid / out_stall): status, data_byte,
//   target_address, directory_entry, table_entry.
//   Config: cfg_we writes cfg_wdata into the directory page register;
//   write it only while the core is idle.
//   Sequence: a translation reads the directory entry, the table entry and
//   the data byte in turn, then loads the output register; a directory
//   fault loads it after the directory read. One write per cycle while no
//   walk runs; a walk's three dependent reads share the one memory read port.
//   Reset: the queue empties, the walk sequencer idles, the directory page
//   returns to 0x6c; store contents are undefined until written.
//   A stalled result holds in the output register; the walk then holds and
//   the queue fills until in_stall rises.
// ----------------------------------------------------------------------------
module two_level_page_walk_core #(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pwk_pkg::PAGE_W-1:0]      cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [pwk_pkg::CMD_W-1:0]       command,
    input  logic [pwk_pkg::VA_W-1:0]        address,
    input  logic [pwk_pkg::BYTE_W-1:0]      write_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [pwk_pkg::STATUS_W-1:0]    status,
    output logic [pwk_pkg::BYTE_W-1:0]      data_byte,
    output logic [pwk_pkg::STORE_AW-1:0]    target_address,
    output logic [pwk_pkg::BYTE_W-1:0]      directory_entry,
    output logic [pwk_pkg::BYTE_W-1:0]      table_entry
);
    import pwk_pkg::*;

    logic [PAGE_W-1:0]  dir_page_reg;
    logic               push;
    logic               pop;
    q_entry_t           push_entry;
    q_entry_t           pop_entry;
    q_status_t          q_status;

    // Directory page register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_page_reg <= DIR_RESET;
        end
        else if (cfg_we)
        begin
            dir_page_reg <= cfg_wdata;
        end
    end

    pwk_front u_front
    (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    pwk_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_status   (q_status)
    );

    pwk_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .dir_page        (dir_page_reg),
        .q_status        (q_status),
        .pop_entry       (pop_entry),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .data_byte       (data_byte),
        .target_address  (target_address),
        .directory_entry (directory_entry),
        .table_entry     (table_entry)
    );

    // A fault result carries only the directory entry
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FAULT) |->
            (data_byte == '0) && (target_address == '0) && (table_entry == '0))
    else $error("fault result with nonzero payload");

    // Memory or disk service follows the table entry's valid bit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == ST_MEM) || (status == ST_DISK)) |->
            directory_entry[VALID_BIT] &&
            (table_entry[VALID_BIT] == (status == ST_MEM)) &&
            (target_address[STORE_AW-1 -: PAGE_W] == table_entry[PAGE_W-1:0]))
    else $error("served result inconsistent with walk entries");

    // Never pop from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
    else $error("queue underflow");

endmodule

>>> sv/pwk_front.sv
// ----------------------------------------------------------------------------
// pwk_front
// Input side: accepts transactions, decodes the command into a queue
// operation and drops unused command codes.
// ----------------------------------------------------------------------------
module pwk_front
(
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pwk_pkg::CMD_W-1:0]     command,
    input  logic [pwk_pkg::VA_W-1:0]      address,
    input  logic [pwk_pkg::BYTE_W-1:0]    write_data,
    input  pwk_pkg::q_status_t            q_status,
    output logic                          push,
    output pwk_pkg::q_entry_t             push_entry
);
    import pwk_pkg::*;

    logic accept;
    logic known_cmd;

    // Stall while the queue has no room
    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    // Classify the command
    always_comb
    begin
        known_cmd      = 1'b1;
        push_entry.op  = OP_WALK;
        case (command)
            CMD_WR_MEM:  push_entry.op = OP_WR_MEM;
            CMD_WR_DISK: push_entry.op = OP_WR_DISK;
            CMD_WALK:    push_entry.op = OP_WALK;
            default:     known_cmd     = 1'b0;
        endcase
        push_entry.addr  = address;
        push_entry.wdata = write_data;
    end

    // Drop unused codes after accepting them
    assign push = accept && known_cmd;

endmodule

>>> sv/pwk_fifo.sv
// ----------------------------------------------------------------------------
// pwk_fifo
// Short queue between front and back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module pwk_fifo #(
    parameter int DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pwk_pkg::q_entry_t    push_entry,
    input  logic                 pop,
    output pwk_pkg::q_entry_t    pop_entry,
    output pwk_pkg::q_status_t   q_status
);
    import pwk_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    q_entry_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == FULL_CNT);
    assign pop_entry      = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed transaction
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> sv/pwk_back.sv
// ----------------------------------------------------------------------------
// pwk_back
// Execution side: owns the memory and disk stores, applies byte writes and
// runs the directory / table / data read sequence for translations, ending
// early on a directory fault, then holds the result in an output register.
// ----------------------------------------------------------------------------
module pwk_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [pwk_pkg::PAGE_W-1:0]      dir_page,
    input  pwk_pkg::q_status_t              q_status,
    input  pwk_pkg::q_entry_t               pop_entry,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [pwk_pkg::STATUS_W-1:0]    status,
    output logic [pwk_pkg::BYTE_W-1:0]      data_byte,
    output logic [pwk_pkg::STORE_AW-1:0]    target_address,
    output logic [pwk_pkg::BYTE_W-1:0]      directory_entry,
    output logic [pwk_pkg::BYTE_W-1:0]      table_entry
);
    import pwk_pkg::*;

    localparam int STORE_DEPTH = 1 << STORE_AW;

    // Stores
    logic [BYTE_W-1:0]   mem_store  [STORE_DEPTH];
    logic [BYTE_W-1:0]   disk_store [STORE_DEPTH];
    logic [BYTE_W-1:0]   mem_rdata_reg;
    logic [BYTE_W-1:0]   disk_rdata_reg;

    // Walk state
    b_state_t            state_reg;
    b_state_t            state_next;
    logic [VA_W-1:0]     job_addr_reg;
    logic [BYTE_W-1:0]   pde_reg;
    logic [BYTE_W-1:0]   pte_reg;

    // Output register
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic [STORE_AW-1:0]  target_reg;
    logic [BYTE_W-1:0]    pde_out_reg;
    logic [BYTE_W-1:0]    pte_out_reg;

    // Control
    logic                 out_free;
    logic                 can_start;
    logic                 start_walk;
    logic                 mem_we;
    logic                 disk_we;
    logic                 mem_re;
    logic                 disk_re;
    logic [STORE_AW-1:0]  rd_addr;
    logic                 load_fault;
    logic                 load_hit;
    logic [BYTE_W-1:0]    hit_byte;

    assign out_free  = !out_valid_reg || !out_stall;
    assign can_start = (state_reg == BS_IDLE) || ((state_reg == BS_DAT) && out_free);
    assign pop       = can_start && !q_status.empty;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE:
            begin
                if (pop && (pop_entry.op == OP_WALK))
                begin
                    state_next = BS_DIR;
                end
            end
            BS_DIR:
            begin
                if (mem_rdata_reg[VALID_BIT])
                begin
                    state_next = BS_TAB;
                end
                else if (out_free)
                begin
                    state_next = BS_IDLE;
                end
            end
            BS_TAB:
            begin
                state_next = BS_DAT;
            end
            BS_DAT:
            begin
                if (out_free)
                begin
                    state_next = (pop && (pop_entry.op == OP_WALK)) ? BS_DIR : BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // Store strobes and read address
    always_comb
    begin
        start_walk = pop && (pop_entry.op == OP_WALK);
        mem_we     = pop && (pop_entry.op == OP_WR_MEM);
        disk_we    = pop && (pop_entry.op == OP_WR_DISK);
        mem_re     = 1'b0;
        disk_re    = 1'b0;
        rd_addr    = {dir_page, pop_entry.addr[VA_W-1 -: OFF_W]};
        load_fault = 1'b0;
        load_hit   = 1'b0;
        case (state_reg)
            BS_IDLE:
            begin
                mem_re = start_walk;
            end
            BS_DIR:
            begin
                // Table entry read, or fault result
                if (mem_rdata_reg[VALID_BIT])
                begin
                    mem_re  = 1'b1;
                    rd_addr = {mem_rdata_reg[PAGE_W-1:0], job_addr_reg[2*OFF_W-1 -: OFF_W]};
                end
                else
                begin
                    load_fault = out_free;
                end
            end
            BS_TAB:
            begin
                // Data byte read from both stores
                mem_re  = 1'b1;
                disk_re = 1'b1;
                rd_addr = {mem_rdata_reg[PAGE_W-1:0], job_addr_reg[OFF_W-1:0]};
            end
            BS_DAT:
            begin
                load_hit = out_free;
                mem_re   = start_walk;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    assign hit_byte = pte_reg[VALID_BIT] ? mem_rdata_reg : disk_rdata_reg;

    // Memory store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_store[pop_entry.addr[STORE_AW-1:0]] <= pop_entry.wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem_store[rd_addr];
        end
    end

    // Disk store
    always_ff @(posedge clk)
    begin
        if (disk_we)
        begin
            disk_store[pop_entry.addr[STORE_AW-1:0]] <= pop_entry.wdata;
        end
        if (disk_re)
        begin
            disk_rdata_reg <= disk_store[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_fault || load_hit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Walk payload: hold address and entries along the sequence
    always_ff @(posedge clk)
    begin
        if (start_walk)
        begin
            job_addr_reg <= pop_entry.addr;
        end
        if (state_reg == BS_DIR)
        begin
            pde_reg <= mem_rdata_reg;
        end
        if (state_reg == BS_TAB)
        begin
            pte_reg <= mem_rdata_reg;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load_fault)
        begin
            status_reg  <= ST_FAULT;
            byte_reg    <= '0;
            target_reg  <= '0;
            pde_out_reg <= mem_rdata_reg;
            pte_out_reg <= '0;
        end
        else if (load_hit)
        begin
            status_reg  <= pte_reg[VALID_BIT] ? ST_MEM : ST_DISK;
            byte_reg    <= hit_byte;
            target_reg  <= {pte_reg[PAGE_W-1:0], job_addr_reg[OFF_W-1:0]};
            pde_out_reg <= pde_reg;
            pte_out_reg <= pte_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign data_byte       = byte_reg;
    assign target_address  = target_reg;
    assign directory_entry = pde_out_reg;
    assign table_entry     = pte_out_reg;

endmodule
